/* rtl/midi_file_byte_parser_core_macros.svh */
// assertion macros for the midi file parser
// used by the files that assert; no dependencies
`ifndef MIDI_FILE_BYTE_PARSER_CORE_MACROS_SVH
`define MIDI_FILE_BYTE_PARSER_CORE_MACROS_SVH

// implication checked at every clock edge outside reset
`define MFP_ASSERT_IMP(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define MFP_ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* rtl/mfp_pkg.sv */
// package for the midi file parser: phase codes, result kinds, error codes
// no dependencies
package mfp_pkg;

    typedef enum logic [14:0] {
        PH_MAGIC  = 15'd1 << 0,
        PH_HLEN   = 15'd1 << 1,
        PH_HBODY  = 15'd1 << 2,
        PH_TMAGIC = 15'd1 << 3,
        PH_TLEN   = 15'd1 << 4,
        PH_DELTA  = 15'd1 << 5,
        PH_STATUS = 15'd1 << 6,
        PH_DATA1  = 15'd1 << 7,
        PH_DATA2  = 15'd1 << 8,
        PH_MTYPE  = 15'd1 << 9,
        PH_MLEN   = 15'd1 << 10,
        PH_SYSLEN = 15'd1 << 11,
        PH_SKIP   = 15'd1 << 12,
        PH_TEMPO  = 15'd1 << 13,
        PH_DONE   = 15'd1 << 14
    } phase_t;

    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_NOTEOFF = 3'd1;
    localparam logic [2:0] KIND_NOTEON  = 3'd2;
    localparam logic [2:0] KIND_CONTROL = 3'd3;
    localparam logic [2:0] KIND_PROGRAM = 3'd4;
    localparam logic [2:0] KIND_TEMPO   = 3'd5;
    localparam logic [2:0] KIND_ERROR   = 3'd6;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_MTHD   = 3'd1;
    localparam logic [2:0] ERR_HDR_LEN   = 3'd2;
    localparam logic [2:0] ERR_FORMAT    = 3'd3;
    localparam logic [2:0] ERR_NO_MTRK   = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED = 3'd5;

    localparam logic [32:0] CONSUMED_MAX = 33'h1_FFFF_FFFF;
    localparam logic [7:0]  META_TEMPO   = 8'h51;
    localparam logic [7:0]  STATUS_META  = 8'hFF;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [3:0]  channel;
        logic [6:0]  first_data;
        logic [6:0]  second_data;
        logic [31:0] tick;
        logic [23:0] tempo_us;
        logic [1:0]  file_format;
        logic [15:0] track_count;
        logic [15:0] division;
        logic [2:0]  error_code;
        logic        done;
    } result_t;

    function automatic logic [7:0] hdr_mark(input logic [1:0] idx);
        case (idx)
            2'd0: hdr_mark = 8'h4D;
            2'd1: hdr_mark = 8'h54;
            2'd2: hdr_mark = 8'h68;
            default: hdr_mark = 8'h64;
        endcase
    endfunction

    function automatic logic [7:0] trk_mark(input logic [1:0] idx);
        case (idx)
            2'd0: trk_mark = 8'h4D;
            2'd1: trk_mark = 8'h54;
            2'd2: trk_mark = 8'h72;
            default: trk_mark = 8'h6B;
        endcase
    endfunction

endpackage

/* rtl/mfp_parse.sv */
// byte parser state: one file byte per cycle while byte_en is high, at most one result per byte
// depends on mfp_pkg and the assertion macros
`include "midi_file_byte_parser_core_macros.svh"
module mfp_parse import mfp_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          byte_en,
    input  logic [7:0]    data_byte,
    input  logic          start_of_file,
    input  logic          end_of_file,
    output result_t       result
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  field_counter_reg, field_counter_next;
    logic [31:0] chunk_length_reg, chunk_length_next;
    logic [32:0] chunk_consumed_reg, chunk_consumed_next;
    logic [31:0] track_tick_reg, track_tick_next;
    logic [31:0] varlen_reg, varlen_next;
    logic [7:0]  running_status_reg, running_status_next;
    logic [7:0]  event_status_reg, event_status_next;
    logic [6:0]  held_data_reg, held_data_next;
    logic [7:0]  meta_type_reg, meta_type_next;
    logic [31:0] skip_reg, skip_next;
    logic [23:0] tempo_reg, tempo_next;
    logic [15:0] tracks_left_reg, tracks_left_next;
    logic [47:0] header_reg, header_next;
    logic [2:0]  error_reg, error_next;
    logic        finished_reg, finished_next;

    always_comb begin
        phase_t      ph;
        logic [2:0]  fc, cnt1;
        logic [31:0] clen;
        logic [32:0] cons;
        logic [31:0] ttick, vacc, skip, vl;
        logic [7:0]  rs, es, mt;
        logic [6:0]  hd;
        logic [23:0] tmp;
        logic [15:0] tl;
        logic [47:0] hw;
        logic [2:0]  err;
        logic        fin;
        logic        ev_done, em, redo;
        logic [2:0]  ek;
        logic [3:0]  ech;
        logic [6:0]  ed1, ed2;
        logic [23:0] etmp;
        logic [3:0]  hi;

        ph = phase_reg; fc = field_counter_reg; clen = chunk_length_reg;
        cons = chunk_consumed_reg; ttick = track_tick_reg; vacc = varlen_reg;
        rs = running_status_reg; es = event_status_reg; hd = held_data_reg;
        mt = meta_type_reg; skip = skip_reg; tmp = tempo_reg;
        tl = tracks_left_reg; hw = header_reg; err = error_reg;
        fin = finished_reg;
        em = 1'b0; ek = KIND_HEADER; ech = '0; ed1 = '0; ed2 = '0; etmp = '0;
        ev_done = 1'b0; redo = 1'b0;
        cnt1 = fc + 3'd1;
        vl = {vacc[24:0], data_byte[6:0]};
        hi = es[7:4];

        if (start_of_file) begin
            ph = PH_MAGIC; fc = '0; clen = '0; cons = '0; ttick = '0; vacc = '0;
            rs = '0; es = '0; hd = '0; mt = '0; skip = '0; tmp = '0; tl = '0;
            hw = '0; err = ERR_NONE; fin = 1'b0;
            cnt1 = 3'd1;
            hi = 4'h0;
        end

        if (err == ERR_NONE && !fin) begin
            if ((ph != PH_MAGIC) && (ph != PH_HLEN) && (ph != PH_HBODY) &&
                (ph != PH_TMAGIC) && (ph != PH_TLEN) && (ph != PH_DONE) &&
                cons != CONSUMED_MAX) begin
                cons = cons + 33'd1;
            end
            case (ph)
                PH_MAGIC, PH_TMAGIC: begin
                    if (data_byte != ((ph == PH_MAGIC) ? hdr_mark(fc[1:0])
                                                       : trk_mark(fc[1:0]))) begin
                        err = (ph == PH_MAGIC) ? ERR_NO_MTHD : ERR_NO_MTRK;
                    end else if (cnt1 == 3'd4) begin
                        fc = '0; clen = '0;
                        ph = (ph == PH_MAGIC) ? PH_HLEN : PH_TLEN;
                    end else begin
                        fc = cnt1;
                    end
                end
                PH_HLEN: begin
                    clen = {clen[23:0], data_byte};
                    fc = cnt1;
                    if (cnt1 == 3'd4) begin
                        if (clen != 32'd6) begin
                            err = ERR_HDR_LEN;
                        end else begin
                            fc = '0; hw = '0; ph = PH_HBODY;
                        end
                    end
                end
                PH_HBODY: begin
                    hw = {hw[39:0], data_byte};
                    fc = cnt1;
                    if (cnt1 == 3'd2 && hw > 48'd2) begin
                        err = ERR_FORMAT;
                    end else if (cnt1 == 3'd6) begin
                        fc = '0;
                        tl = hw[31:16];
                        em = 1'b1; ek = KIND_HEADER;
                        if (hw[31:16] == 16'd0) begin
                            fin = 1'b1; ph = PH_DONE;
                        end else begin
                            ph = PH_TMAGIC;
                        end
                    end
                end
                PH_TLEN: begin
                    clen = {clen[23:0], data_byte};
                    fc = cnt1;
                    if (cnt1 == 3'd4) begin
                        fc = '0; cons = '0; ttick = '0; rs = '0;
                        ev_done = 1'b1;
                    end
                end
                PH_DELTA: begin
                    vacc = vl;
                    if (!data_byte[7]) begin
                        ttick = ttick + vl;
                        vacc = '0;
                        ph = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (data_byte[7]) begin
                        es = data_byte;
                        rs = (data_byte[7:4] != 4'hF) ? data_byte : 8'h00;
                        vacc = '0;
                        if (data_byte[7:4] != 4'hF) ph = PH_DATA1;
                        else if (data_byte == STATUS_META) ph = PH_MTYPE;
                        else ph = PH_SYSLEN;
                    end else if (rs != 8'h00) begin
                        es = rs;
                        if (rs[7:4] == 4'hC) begin
                            em = 1'b1; ek = KIND_PROGRAM; ech = rs[3:0];
                            ed1 = data_byte[6:0];
                            ev_done = 1'b1;
                        end else if (rs[7:4] == 4'hD) begin
                            ev_done = 1'b1;
                        end else begin
                            hd = data_byte[6:0]; ph = PH_DATA2;
                        end
                    end else begin
                        cons = cons - 33'd1;
                        ev_done = 1'b1;
                        redo = 1'b1;
                    end
                end
                PH_DATA1: begin
                    if (hi == 4'hC) begin
                        em = 1'b1; ek = KIND_PROGRAM; ech = es[3:0];
                        ed1 = data_byte[6:0];
                        ev_done = 1'b1;
                    end else if (hi == 4'hD) begin
                        ev_done = 1'b1;
                    end else begin
                        hd = data_byte[6:0]; ph = PH_DATA2;
                    end
                end
                PH_DATA2: begin
                    ech = es[3:0]; ed1 = hd; ed2 = data_byte[6:0];
                    if (hi == 4'h8) begin
                        em = 1'b1; ek = KIND_NOTEOFF;
                    end else if (hi == 4'h9) begin
                        em = 1'b1;
                        ek = (data_byte[6:0] == 7'd0) ? KIND_NOTEOFF : KIND_NOTEON;
                    end else if (hi == 4'hB) begin
                        em = 1'b1; ek = KIND_CONTROL;
                    end
                    ev_done = 1'b1;
                end
                PH_MTYPE: begin
                    mt = data_byte; vacc = '0; ph = PH_MLEN;
                end
                PH_MLEN, PH_SYSLEN: begin
                    vacc = vl;
                    if (!data_byte[7]) begin
                        vacc = '0;
                        if (ph == PH_MLEN && mt == META_TEMPO && vl == 32'd3) begin
                            tmp = '0; fc = '0; ph = PH_TEMPO;
                        end else if (vl == 32'd0) begin
                            ev_done = 1'b1;
                        end else begin
                            skip = vl; ph = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    skip = skip - 32'd1;
                    if (skip == 32'd0) ev_done = 1'b1;
                end
                PH_TEMPO: begin
                    tmp = {tmp[15:0], data_byte};
                    fc = cnt1;
                    if (cnt1 >= 3'd3) begin
                        fc = '0;
                        em = 1'b1; ek = KIND_TEMPO; etmp = tmp;
                        ev_done = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (ev_done) begin
                ph = PH_DELTA;
                vacc = '0;
                if (cons >= {1'b0, clen}) begin
                    tl = tl - 16'd1;
                    if (tl == 16'd0) begin
                        fin = 1'b1; ph = PH_DONE;
                    end else begin
                        ph = PH_TMAGIC; fc = '0;
                    end
                end
            end

            // a data byte with no running status is handled again
            if (redo && ph != PH_DONE) begin
                if (ph == PH_DELTA) begin
                    cons = (cons != CONSUMED_MAX) ? cons + 33'd1 : cons;
                    vacc = {25'd0, data_byte[6:0]};
                    if (!data_byte[7]) begin
                        ttick = ttick + {25'd0, data_byte[6:0]};
                        vacc = '0;
                        ph = PH_STATUS;
                    end
                end else begin
                    if (data_byte != trk_mark(2'd0)) begin
                        err = ERR_NO_MTRK;
                    end else begin
                        fc = 3'd1;
                    end
                end
            end

            if (err == ERR_NONE && !fin && end_of_file) err = ERR_TRUNCATED;
            if (err != ERR_NONE) begin
                ph = PH_DONE;
                em = 1'b1; ek = KIND_ERROR;
            end
        end

        phase_next = ph; field_counter_next = fc; chunk_length_next = clen;
        chunk_consumed_next = cons; track_tick_next = ttick; varlen_next = vacc;
        running_status_next = rs; event_status_next = es; held_data_next = hd;
        meta_type_next = mt; skip_next = skip; tempo_next = tmp;
        tracks_left_next = tl; header_next = hw; error_next = err;
        finished_next = fin;

        result.valid = byte_en & em;
        result.kind = ek;
        if (ek == KIND_ERROR) begin
            result.channel = '0; result.first_data = '0; result.second_data = '0;
            result.tick = '0; result.tempo_us = '0; result.file_format = '0;
            result.track_count = '0; result.division = '0;
            result.error_code = err; result.done = 1'b0;
        end else begin
            result.channel = ech; result.first_data = ed1; result.second_data = ed2;
            result.tick = (ek == KIND_HEADER) ? 32'd0 : ttick;
            result.tempo_us = etmp;
            result.file_format = hw[33:32];
            result.track_count = hw[31:16];
            result.division = hw[15:0];
            result.error_code = ERR_NONE;
            result.done = fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MAGIC;
            field_counter_reg <= '0;
            chunk_length_reg <= '0;
            chunk_consumed_reg <= '0;
            track_tick_reg <= '0;
            varlen_reg <= '0;
            running_status_reg <= '0;
            event_status_reg <= '0;
            held_data_reg <= '0;
            meta_type_reg <= '0;
            skip_reg <= '0;
            tempo_reg <= '0;
            tracks_left_reg <= '0;
            header_reg <= '0;
            error_reg <= ERR_NONE;
            finished_reg <= 1'b0;
        end else if (byte_en) begin
            phase_reg <= phase_next;
            field_counter_reg <= field_counter_next;
            chunk_length_reg <= chunk_length_next;
            chunk_consumed_reg <= chunk_consumed_next;
            track_tick_reg <= track_tick_next;
            varlen_reg <= varlen_next;
            running_status_reg <= running_status_next;
            event_status_reg <= event_status_next;
            held_data_reg <= held_data_next;
            meta_type_reg <= meta_type_next;
            skip_reg <= skip_next;
            tempo_reg <= tempo_next;
            tracks_left_reg <= tracks_left_next;
            header_reg <= header_next;
            error_reg <= error_next;
            finished_reg <= finished_next;
        end
    end

    `MFP_ASSERT_IMP(a_err_done, aclk, aresetn, error_reg != ERR_NONE, phase_reg == PH_DONE, "error without done phase")
    `MFP_ASSERT_IMP(a_fin_done, aclk, aresetn, finished_reg, phase_reg == PH_DONE, "finished without done phase")
    `MFP_ASSERT_IMP(a_quiet, aclk, aresetn, (error_reg != ERR_NONE || finished_reg) && !start_of_file, !result.valid, "result after end")
    `MFP_ASSERT_IMP(a_err_kind, aclk, aresetn, result.valid && result.kind == KIND_ERROR, result.error_code != ERR_NONE, "error result without code")

endmodule

/* rtl/midi_file_byte_parser_core.sv */
// top level of the midi file parser: handshake and result register
// depends on mfp_pkg, mfp_parse and the assertion macros
//
//  channel | direction | word
//  s_      | in        | data_byte, start_of_file, end_of_file
//  m_      | out       | kind .. done_res, one result per word at most
//
//  one word per cycle while s_ready is high; a result appears in the cycle after
//  its word is taken, through the single parse step between the state and the
//  result register; aresetn clears all parser state synchronously
//  s_ready stays high while the result register is empty or being emptied
`include "midi_file_byte_parser_core_macros.svh"
module midi_file_byte_parser_core import mfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_of_file,
    input  logic        s_end_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [3:0]  m_channel,
    output logic [6:0]  m_first_data,
    output logic [6:0]  m_second_data,
    output logic [31:0] m_tick,
    output logic [23:0] m_tempo_us,
    output logic [1:0]  m_file_format,
    output logic [15:0] m_track_count,
    output logic [15:0] m_division,
    output logic [2:0]  m_error_code,
    output logic        m_done_res
);

    result_t res;
    result_t out_reg;
    logic    take;

    assign s_ready = !out_reg.valid || m_ready;
    assign take = s_valid && s_ready;

    mfp_parse u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .byte_en       (take),
        .data_byte     (s_data_byte),
        .start_of_file (s_start_of_file),
        .end_of_file   (s_end_of_file),
        .result        (res)
    );

    // res.valid already carries the input handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg <= '0;
        end else if (s_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_reg.valid;
    assign m_kind = out_reg.kind;
    assign m_channel = out_reg.channel;
    assign m_first_data = out_reg.first_data;
    assign m_second_data = out_reg.second_data;
    assign m_tick = out_reg.tick;
    assign m_tempo_us = out_reg.tempo_us;
    assign m_file_format = out_reg.file_format;
    assign m_track_count = out_reg.track_count;
    assign m_division = out_reg.division;
    assign m_error_code = out_reg.error_code;
    assign m_done_res = out_reg.done;

    `MFP_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_tick) && $stable(m_kind), "result changed while stalled")
    `MFP_ASSERT_IMP(a_stall, aclk, aresetn, m_valid && !m_ready, !s_ready, "word taken while result stalled")
    `MFP_ASSERT_NEXT(a_fill, aclk, aresetn, take && res.valid, m_valid, "result lost")

endmodule
